@@ rtl/linked_list_table_manager_assert.svh @@
// Assertion macros shared by the list manager RTL.
`ifndef LINKED_LIST_TABLE_MANAGER_ASSERT_SVH
`define LINKED_LIST_TABLE_MANAGER_ASSERT_SVH

// Same-cycle implication, sampled on clk, masked during reset.
`define LLT_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("llt assertion failed");

// Next-cycle implication, sampled on clk, masked during reset.
`define LLT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("llt assertion failed");

`endif

@@ rtl/llt_pkg.sv @@
// ----------------------------------------------------------------------------
// llt_pkg
// Types and constants for the linked list table manager.
// ----------------------------------------------------------------------------
package llt_pkg;

  localparam int POOL_NODES   = 1024;
  localparam int HANDLE_W     = 10;
  localparam int VALUE_W      = 32;
  localparam int HANDLE_SPACE = 1 << HANDLE_W;
  localparam int POOL_LIMIT   = (POOL_NODES < HANDLE_SPACE) ? POOL_NODES : HANDLE_SPACE;
  localparam int IDX_W        = $clog2(POOL_LIMIT);
  localparam int ALLOC_W      = HANDLE_W + 1;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_INS_HEAD   = 3'd0,
    OP_INS_TAIL   = 3'd1,
    OP_INS_AFTER  = 3'd2,
    OP_INS_BEFORE = 3'd3,
    OP_DELETE     = 3'd4,
    OP_MOVE_HEAD  = 3'd5,
    OP_MOVE_TAIL  = 3'd6,
    OP_READ       = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_EVAL,
    SQ_UNLINK,
    SQ_LINK1,
    SQ_LINK2,
    SQ_DONE
  } seq_state_t;

  // Classified operation passed from front to back.
  typedef struct packed {
    opcode_t               op;
    logic                  is_insert;
    logic                  is_move;
    logic [HANDLE_W-1:0]   handle;
    logic [VALUE_W-1:0]    value;
  } cmd_t;

  typedef struct packed {
    status_t               status;
    logic [HANDLE_W-1:0]   node;
    logic [VALUE_W-1:0]    value;
    logic [HANDLE_W-1:0]   next;
    logic [HANDLE_W-1:0]   prev;
  } res_t;

endpackage

@@ rtl/llt_op_if.sv @@
// ----------------------------------------------------------------------------
// llt_op_if
// Operation channel: valid/ready with opcode, handle and value.
// ----------------------------------------------------------------------------
interface llt_op_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         opcode;
  logic [llt_pkg::HANDLE_W-1:0]       handle;
  logic signed [llt_pkg::VALUE_W-1:0] item_value;

  modport source (output valid, opcode, handle, item_value, input ready);
  modport sink   (input valid, opcode, handle, item_value, output ready);
endinterface

@@ rtl/llt_res_if.sv @@
// ----------------------------------------------------------------------------
// llt_res_if
// Result channel: valid/ready with status, node, value and neighbours.
// ----------------------------------------------------------------------------
interface llt_res_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic [llt_pkg::HANDLE_W-1:0]       node_handle;
  logic signed [llt_pkg::VALUE_W-1:0] node_value;
  logic [llt_pkg::HANDLE_W-1:0]       next_handle;
  logic [llt_pkg::HANDLE_W-1:0]       prev_handle;

  modport source (output valid, status, node_handle, node_value, next_handle, prev_handle,
                  input ready);
  modport sink   (input valid, status, node_handle, node_value, next_handle, prev_handle,
                  output ready);
endinterface

@@ rtl/llt_front.sv @@
// ----------------------------------------------------------------------------
// llt_front
// Accepts operations, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`include "linked_list_table_manager_assert.svh"

module llt_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    opcode,
  input  logic [llt_pkg::HANDLE_W-1:0]  handle,
  input  logic [llt_pkg::VALUE_W-1:0]   item_value,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output llt_pkg::cmd_t                 cmd
);

  llt_pkg::cmd_t                 queue [llt_pkg::QUEUE_DEPTH];
  logic [llt_pkg::QPTR_W-1:0]    wr_ptr;
  logic [llt_pkg::QPTR_W-1:0]    rd_ptr;
  logic [llt_pkg::QCNT_W-1:0]    count;
  llt_pkg::cmd_t                 classed;
  logic                          push;
  logic                          pop;

  always_comb begin
    classed.op        = llt_pkg::opcode_t'(opcode);
    classed.is_insert = (classed.op == llt_pkg::OP_INS_HEAD) ||
                        (classed.op == llt_pkg::OP_INS_TAIL) ||
                        (classed.op == llt_pkg::OP_INS_AFTER) ||
                        (classed.op == llt_pkg::OP_INS_BEFORE);
    classed.is_move   = (classed.op == llt_pkg::OP_MOVE_HEAD) ||
                        (classed.op == llt_pkg::OP_MOVE_TAIL);
    classed.handle    = handle;
    classed.value     = item_value;
  end

  assign in_ready  = (count != llt_pkg::QCNT_W'(llt_pkg::QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= classed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `LLT_ASSERT_IMPL(a_queue_bound, 1'b1, count <= llt_pkg::QCNT_W'(llt_pkg::QUEUE_DEPTH))

endmodule

@@ rtl/llt_back.sv @@
// ----------------------------------------------------------------------------
// llt_back
// Executes queued operations against the link, value and live memories.
// ----------------------------------------------------------------------------
`include "linked_list_table_manager_assert.svh"

module llt_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  llt_pkg::cmd_t  cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output llt_pkg::res_t  res_out
);

  // node memories (entry 0 links live in head/tail)
  logic [llt_pkg::HANDLE_W-1:0] next_mem [llt_pkg::POOL_LIMIT];
  logic [llt_pkg::HANDLE_W-1:0] prev_mem [llt_pkg::POOL_LIMIT];
  logic [llt_pkg::VALUE_W-1:0]  val_mem  [llt_pkg::POOL_LIMIT];
  logic                         live_mem [llt_pkg::POOL_LIMIT];

  llt_pkg::seq_state_t          state, state_next;
  llt_pkg::cmd_t                cur;
  llt_pkg::res_t                res, ev_res;
  logic [llt_pkg::HANDLE_W-1:0] rd_next, rd_prev;
  logic [llt_pkg::VALUE_W-1:0]  rd_val;
  logic                         rd_live;
  logic [llt_pkg::HANDLE_W-1:0] head, tail;
  logic [llt_pkg::ALLOC_W-1:0]  alloc;
  logic [llt_pkg::HANDLE_W-1:0] node, pos, rgt;
  logic [llt_pkg::HANDLE_W-1:0] ev_node, ev_pos, ev_rgt;
  logic [llt_pkg::HANDLE_W-1:0] lk_pos, lk_rgt;
  logic                         live, full, ins_ok, load, pop;
  logic [llt_pkg::HANDLE_W-1:0] new_id;
  logic                         res_clean;

  logic                         nw_en, pw_en, lw_en, lw_data;
  logic [llt_pkg::HANDLE_W-1:0] nw_addr, nw_data, pw_addr, pw_data, lw_addr;

  assign pop    = cmd_valid && cmd_ready;
  assign load   = (state == llt_pkg::SQ_DONE) && (!res_valid || res_ready);
  assign full   = alloc >= llt_pkg::ALLOC_W'(llt_pkg::POOL_LIMIT);
  assign live   = (cur.handle != '0) && ({1'b0, cur.handle} < alloc) && rd_live;
  assign new_id = alloc[llt_pkg::HANDLE_W-1:0];

  // evaluation of the read-back node
  always_comb begin
    ev_res  = '{status: llt_pkg::ST_BAD, node: cur.handle, value: '0, next: '0, prev: '0};
    ev_node = cur.handle;
    ev_pos  = rd_prev;
    ev_rgt  = rd_next;
    ins_ok  = 1'b0;
    unique case (cur.op)
      llt_pkg::OP_INS_HEAD, llt_pkg::OP_INS_TAIL,
      llt_pkg::OP_INS_AFTER, llt_pkg::OP_INS_BEFORE: begin
        ev_node = new_id;
        unique case (cur.op)
          llt_pkg::OP_INS_HEAD: begin
            ev_pos = '0;
            ev_rgt = head;
          end
          llt_pkg::OP_INS_TAIL: begin
            ev_pos = tail;
            ev_rgt = '0;
          end
          llt_pkg::OP_INS_AFTER: begin
            ev_pos = cur.handle;
            ev_rgt = rd_next;
          end
          default: begin
            ev_pos = rd_prev;
            ev_rgt = cur.handle;
          end
        endcase
        if (full) begin
          ev_res.status = llt_pkg::ST_FULL;
        end else if (!cur.is_insert || (cur.op == llt_pkg::OP_INS_HEAD) ||
                     (cur.op == llt_pkg::OP_INS_TAIL) || live) begin
          ins_ok = 1'b1;
          ev_res = '{status: llt_pkg::ST_OK, node: new_id, value: cur.value,
                     next: ev_rgt, prev: ev_pos};
        end
      end
      llt_pkg::OP_READ: begin
        if (cur.handle == '0) begin
          ev_res = '{status: llt_pkg::ST_OK, node: '0, value: '0, next: head, prev: tail};
        end else if (live) begin
          ev_res = '{status: llt_pkg::ST_OK, node: cur.handle, value: rd_val,
                     next: rd_next, prev: rd_prev};
        end
      end
      default: begin
        if (live) begin
          ev_res = '{status: llt_pkg::ST_OK, node: cur.handle, value: rd_val,
                     next: rd_next, prev: rd_prev};
        end
      end
    endcase
  end

  // relink target for the link steps; moves pick it after the unlink
  always_comb begin
    lk_pos = pos;
    lk_rgt = rgt;
    if (cur.op == llt_pkg::OP_MOVE_HEAD) begin
      lk_pos = '0;
      lk_rgt = head;
    end else if (cur.op == llt_pkg::OP_MOVE_TAIL) begin
      lk_pos = tail;
      lk_rgt = '0;
    end
  end

  always_comb begin
    state_next = state;
    cmd_ready  = (state == llt_pkg::SQ_IDLE);
    nw_en = 1'b0; nw_addr = '0; nw_data = '0;
    pw_en = 1'b0; pw_addr = '0; pw_data = '0;
    lw_en = 1'b0; lw_addr = '0; lw_data = 1'b0;
    unique case (state)
      llt_pkg::SQ_IDLE: begin
        if (cmd_valid) begin
          state_next = llt_pkg::SQ_EVAL;
        end
      end
      llt_pkg::SQ_EVAL: begin
        state_next = llt_pkg::SQ_DONE;
        if (ev_res.status == llt_pkg::ST_OK) begin
          if (cur.is_insert) begin
            lw_en      = 1'b1;
            lw_addr    = new_id;
            lw_data    = 1'b1;
            state_next = llt_pkg::SQ_LINK1;
          end else if (cur.op != llt_pkg::OP_READ) begin
            state_next = llt_pkg::SQ_UNLINK;
          end
        end
      end
      llt_pkg::SQ_UNLINK: begin
        nw_en = 1'b1; nw_addr = pos; nw_data = rgt;
        pw_en = 1'b1; pw_addr = rgt; pw_data = pos;
        if (cur.op == llt_pkg::OP_DELETE) begin
          lw_en      = 1'b1;
          lw_addr    = node;
          state_next = llt_pkg::SQ_DONE;
        end else begin
          state_next = llt_pkg::SQ_LINK1;
        end
      end
      llt_pkg::SQ_LINK1: begin
        nw_en = 1'b1; nw_addr = node; nw_data = lk_rgt;
        pw_en = 1'b1; pw_addr = node; pw_data = lk_pos;
        state_next = llt_pkg::SQ_LINK2;
      end
      llt_pkg::SQ_LINK2: begin
        nw_en = 1'b1; nw_addr = pos; nw_data = node;
        pw_en = 1'b1; pw_addr = rgt; pw_data = node;
        state_next = llt_pkg::SQ_DONE;
      end
      llt_pkg::SQ_DONE: begin
        if (load) begin
          state_next = llt_pkg::SQ_IDLE;
        end
      end
      default: state_next = llt_pkg::SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= llt_pkg::SQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (nw_en && (nw_addr != '0)) begin
      next_mem[nw_addr[llt_pkg::IDX_W-1:0]] <= nw_data;
    end
    if (pw_en && (pw_addr != '0)) begin
      prev_mem[pw_addr[llt_pkg::IDX_W-1:0]] <= pw_data;
    end
    if (lw_en) begin
      live_mem[lw_addr[llt_pkg::IDX_W-1:0]] <= lw_data;
    end
    if ((state == llt_pkg::SQ_EVAL) && ins_ok) begin
      val_mem[new_id[llt_pkg::IDX_W-1:0]] <= cur.value;
    end
    if (pop) begin
      rd_next <= next_mem[cmd.handle[llt_pkg::IDX_W-1:0]];
      rd_prev <= prev_mem[cmd.handle[llt_pkg::IDX_W-1:0]];
      rd_val  <= val_mem[cmd.handle[llt_pkg::IDX_W-1:0]];
      rd_live <= live_mem[cmd.handle[llt_pkg::IDX_W-1:0]];
    end
  end

  // sentinel links and allocation counter
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      alloc <= llt_pkg::ALLOC_W'(1);
    end else begin
      if (nw_en && (nw_addr == '0)) begin
        head <= nw_data;
      end
      if (pw_en && (pw_addr == '0)) begin
        tail <= pw_data;
      end
      if ((state == llt_pkg::SQ_EVAL) && ins_ok) begin
        alloc <= alloc + 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= cmd;
    end
    if (state == llt_pkg::SQ_EVAL) begin
      res  <= ev_res;
      node <= ev_node;
      pos  <= ev_pos;
      rgt  <= ev_rgt;
    end else if (state == llt_pkg::SQ_LINK1) begin
      pos      <= lk_pos;
      rgt      <= lk_rgt;
      res.next <= lk_rgt;
      res.prev <= lk_pos;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res;
    end
  end

  // error results carry nothing but status and handle
  assign res_clean = (res.value == '0) && (res.next == '0) && (res.prev == '0);

  `LLT_ASSERT_IMPL(a_alloc_bound, 1'b1, alloc <= llt_pkg::ALLOC_W'(llt_pkg::POOL_LIMIT))
  `LLT_ASSERT_IMPL(a_link_node, state == llt_pkg::SQ_LINK1, node != '0)
  `LLT_ASSERT_IMPL(a_err_clean, (state == llt_pkg::SQ_DONE) && (res.status != llt_pkg::ST_OK), res_clean)
  `LLT_ASSERT_NEXT(a_pop_eval, pop, state == llt_pkg::SQ_EVAL)

endmodule

@@ rtl/linked_list_table_manager.sv @@
// ----------------------------------------------------------------------------
// linked_list_table_manager
// Doubly linked list in a fixed node pool, circular around sentinel 0.
// ----------------------------------------------------------------------------
// One operation is handled at a time by the back end: reads, errors and a
// full pool go from EVAL to DONE, inserts through EVAL, LINK1 and LINK2, a
// delete through EVAL and UNLINK, and moves through EVAL, UNLINK, LINK1 and
// LINK2. The sequence is set by the single write port of each link memory,
// which takes one link update per step. A two-entry queue lets new
// operations be taken while one runs, and the result register lets the next
// operation start while a result waits. No clearing pass after reset: the
// live check compares against the allocation counter, so no stale entry is
// ever taken as live.

module linked_list_table_manager (
  input  logic      clk,
  input  logic      rst,
  llt_op_if.sink    op,
  llt_res_if.source res
);

  logic           cmd_valid;
  logic           cmd_ready;
  llt_pkg::cmd_t  cmd;
  llt_pkg::res_t  res_data;

  // front: take op transfers, classify, queue
  llt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (op.valid),
    .in_ready   (op.ready),
    .opcode     (op.opcode),
    .handle     (op.handle),
    .item_value (op.item_value),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  // back: memory sequencer and result register
  llt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_out   (res_data)
  );

  assign res.status      = res_data.status;
  assign res.node_handle = res_data.node;
  assign res.node_value  = res_data.value;
  assign res.next_handle = res_data.next;
  assign res.prev_handle = res_data.prev;

endmodule

@@ dv/linked_list_table_manager_tb.sv @@
// ----------------------------------------------------------------------------
// linked_list_table_manager_tb
// Self-checking bench for the node pool list manager: a directed table, then
// random operation streams, each result checked against a behavioural copy of
// the list kept in the bench or, for marked table rows, a typed-in result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linked_list_table_manager_tb;
  import llt_pkg::*;

  localparam int N_RANDOM    = 576;
  localparam int CYCLE_LIMIT = 400000;
  localparam int USABLE      = POOL_LIMIT;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  llt_op_if  op_ch ();
  llt_res_if res_ch ();

  linked_list_table_manager u_dut (
    .clk (clk),
    .rst (rst),
    .op  (op_ch.sink),
    .res (res_ch.source)
  );

  // Shadow of the list held by the DUT.
  logic [HANDLE_W-1:0] nxt [USABLE];
  logic [HANDLE_W-1:0] prv [USABLE];
  logic [VALUE_W-1:0]  val [USABLE];
  bit                  alive [USABLE];
  int unsigned         next_alloc;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] node;
    logic [VALUE_W-1:0]  value;
    logic [HANDLE_W-1:0] next;
    logic [HANDLE_W-1:0] prev;
  } list_res_t;

  list_res_t pending_res [$];

  int  mismatches = 0;
  int  cycles     = 0;
  bit  quiet      = 1'b0;   // no idling in the final stretch

  function automatic bit node_ok(input logic [HANDLE_W-1:0] h);
    return h != 0 && h < USABLE && alive[h];
  endfunction

  function automatic void splice_after(input int pos, input int n);
    int r;
    r = nxt[pos];
    prv[n] = HANDLE_W'(pos); nxt[n] = HANDLE_W'(r);
    nxt[pos] = HANDLE_W'(n); prv[r] = HANDLE_W'(n);
  endfunction

  function automatic void unsplice(input int n);
    nxt[prv[n]] = nxt[n];
    prv[nxt[n]] = prv[n];
  endfunction

  // Apply one operation to the shadow list, return the result it gives.
  function automatic list_res_t list_apply(input opcode_t opc,
                                           input logic [HANDLE_W-1:0] h,
                                           input logic [VALUE_W-1:0] v);
    list_res_t r;
    int pos, n, onx, opv;
    r = '0;
    r.node = h;
    if (opc inside {OP_INS_HEAD, OP_INS_TAIL, OP_INS_AFTER, OP_INS_BEFORE}) begin
      if (next_alloc >= USABLE) begin
        r.status = ST_FULL;
        return r;
      end
      if (opc == OP_INS_HEAD) pos = 0;
      else if (opc == OP_INS_TAIL) pos = prv[0];
      else begin
        if (!node_ok(h)) begin
          r.status = ST_BAD;
          return r;
        end
        pos = (opc == OP_INS_AFTER) ? h : prv[h];
      end
      n = next_alloc;
      next_alloc++;
      val[n] = v; alive[n] = 1'b1;
      splice_after(pos, n);
      r.status = ST_OK; r.node = HANDLE_W'(n); r.value = v; r.next = nxt[n]; r.prev = prv[n];
      return r;
    end
    if (opc == OP_READ) begin
      if (h == 0) begin
        r.status = ST_OK; r.next = nxt[0]; r.prev = prv[0];
      end else if (node_ok(h)) begin
        r.status = ST_OK; r.value = val[h]; r.next = nxt[h]; r.prev = prv[h];
      end else r.status = ST_BAD;
      return r;
    end
    if (!node_ok(h)) begin
      r.status = ST_BAD;
      return r;
    end
    if (opc == OP_DELETE) begin
      onx = nxt[h]; opv = prv[h];
      unsplice(h);
      alive[h] = 1'b0;
      r.status = ST_OK; r.value = val[h]; r.next = HANDLE_W'(onx); r.prev = HANDLE_W'(opv);
      return r;
    end
    unsplice(h);
    if (opc == OP_MOVE_HEAD) splice_after(0, h);
    else splice_after(prv[0], h);
    r.status = ST_OK; r.value = val[h]; r.next = nxt[h]; r.prev = prv[h];
    return r;
  endfunction

  // Directed table. chk marks rows whose result is typed in here.
  typedef struct {
    opcode_t             opc;
    logic [HANDLE_W-1:0] h;
    logic [VALUE_W-1:0]  v;
    bit                  chk;
    list_res_t           want;
  } dir_row_t;

  dir_row_t dir_tab [] = '{
    '{OP_READ,       10'd0,    32'd0,        1, '{ST_OK,  10'd0,   32'd0, 10'd0, 10'd0}},
    '{OP_READ,       10'd1,    32'd0,        1, '{ST_BAD, 10'd1,   32'd0, 10'd0, 10'd0}},
    '{OP_DELETE,     10'd1023, 32'd0,        1, '{ST_BAD, 10'd1023,32'd0, 10'd0, 10'd0}},
    '{OP_MOVE_HEAD,  10'd0,    32'd0,        1, '{ST_BAD, 10'd0,   32'd0, 10'd0, 10'd0}},
    '{OP_INS_AFTER,  10'd5,    32'd7,        1, '{ST_BAD, 10'd5,   32'd0, 10'd0, 10'd0}},
    '{OP_INS_HEAD,   10'd0,    32'h7FFFFFFF, 1, '{ST_OK,  10'd1,   32'h7FFFFFFF, 10'd0, 10'd0}},
    '{OP_INS_TAIL,   10'd1023, 32'h80000000, 0, '0},
    '{OP_INS_AFTER,  10'd1,    32'hFFFFFFFF, 0, '0},
    '{OP_INS_BEFORE, 10'd1,    32'd0,        0, '0},
    '{OP_INS_BEFORE, 10'd0,    32'd1,        1, '{ST_BAD, 10'd0,   32'd0, 10'd0, 10'd0}},
    '{OP_READ,       10'd0,    32'd0,        0, '0},
    '{OP_MOVE_TAIL,  10'd1,    32'd0,        0, '0},
    '{OP_MOVE_HEAD,  10'd2,    32'd0,        0, '0},
    '{OP_MOVE_HEAD,  10'd2,    32'd0,        0, '0},
    '{OP_MOVE_TAIL,  10'd1,    32'd0,        0, '0},
    '{OP_READ,       10'd3,    32'd0,        0, '0},
    '{OP_DELETE,     10'd3,    32'd0,        0, '0},
    '{OP_DELETE,     10'd3,    32'd0,        1, '{ST_BAD, 10'd3,   32'd0, 10'd0, 10'd0}},
    '{OP_READ,       10'd3,    32'd0,        1, '{ST_BAD, 10'd3,   32'd0, 10'd0, 10'd0}},
    '{OP_INS_HEAD,   10'd0,    32'h12345678, 0, '0},
    '{OP_READ,       10'd0,    32'd0,        0, '0}
  };

  // Expected result queue holds predictor output; override rows keep theirs.
  // valid stays high between back-to-back transfers and drops only to idle.
  task automatic send_op(input opcode_t opc, input logic [HANDLE_W-1:0] h,
                         input logic [VALUE_W-1:0] v, input bit chk,
                         input list_res_t want);
    list_res_t p;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      op_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    op_ch.valid      <= 1'b1;
    op_ch.opcode     <= opc;
    op_ch.handle     <= h;
    op_ch.item_value <= v;
    do @(posedge clk); while (!op_ch.ready);
    p = list_apply(opc, h, v);
    pending_res.push_back(chk ? want : p);
    @(negedge clk);
  endtask

  // Result sink: random back-pressure bursts, transfer checked at rising edge.
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    stall = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (stall > 0 && !quiet) begin
        res_ch.ready <= 1'b0;
        stall--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        res_ch.ready <= 1'b0;
        stall = $urandom_range(0, 12);
      end else res_ch.ready <= 1'b1;
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) begin
        list_res_t got, exp_r;
        got = '{res_ch.status, res_ch.node_handle, res_ch.node_value,
                res_ch.next_handle, res_ch.prev_handle};
        if (pending_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer: %p", got);
        end else begin
          exp_r = pending_res.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, actual %p", exp_r, got);
          end
        end
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Pick a handle: mostly live nodes, sometimes dead, the sentinel or unallocated.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int k;
    k = $urandom_range(0, 9);
    if (k < 7 && next_alloc > 1) begin
      for (int i = 0; i < 8; i++) begin
        int c;
        c = $urandom_range(1, next_alloc - 1);
        if (alive[c]) return HANDLE_W'(c);
      end
      return HANDLE_W'($urandom_range(1, next_alloc - 1));
    end
    if (k == 7) return '0;
    return HANDLE_W'($urandom());
  endfunction

  initial begin
    opcode_t opc;
    int      w;
    op_ch.valid      = 1'b0;
    op_ch.opcode     = OP_READ;
    op_ch.handle     = '0;
    op_ch.item_value = '0;
    for (int i = 0; i < USABLE; i++) begin
      nxt[i] = '0; prv[i] = '0; val[i] = '0; alive[i] = 1'b0;
    end
    next_alloc = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i])
      send_op(dir_tab[i].opc, dir_tab[i].h, dir_tab[i].v, dir_tab[i].chk, dir_tab[i].want);

    // Random part: inserts weighted heavily so the list grows long, with
    // deletes/moves/reads on live nodes and some bad handles mixed in.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n > N_RANDOM - 80) quiet = 1'b1;
      w = $urandom_range(0, 15);
      if (next_alloc < USABLE && w < 9) opc = opcode_t'($urandom_range(0, 3));
      else opc = opcode_t'($urandom_range(0, 7));
      send_op(opc, pick_handle(), $urandom(), 1'b0, '0);
    end
    // A last pair of inserts, then a final read of the sentinel.
    send_op(OP_INS_HEAD, 10'd0, 32'd1, 1'b0, '0);
    send_op(OP_INS_AFTER, 10'd2, 32'd1, 1'b0, '0);
    send_op(OP_READ, 10'd0, 32'd0, 1'b0, '0);
    op_ch.valid <= 1'b0;

    while (pending_res.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending_res.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/llt_pkg.sv
rtl/llt_op_if.sv
rtl/llt_res_if.sv
rtl/llt_front.sv
rtl/llt_back.sv
rtl/linked_list_table_manager.sv
dv/linked_list_table_manager_tb.sv
